FILE: hdl/samp_pkg.sv
// Shared types, widths and constants of the speed adaptive magnet pulser.
package samp_pkg;

  localparam int TIME_BITS    = 20;
  localparam int PERIOD_BITS  = 15;
  localparam int SUM_BITS     = 20;
  localparam int AVG_SHIFT    = 4;
  localparam int CFG_IDX_BITS = 2;
  localparam int PROD_BITS    = PERIOD_BITS + TIME_BITS;
  localparam int DIV_CNT_BITS = $clog2(PROD_BITS);

  typedef logic [TIME_BITS-1:0]   time_t;
  typedef logic [PERIOD_BITS-1:0] period_t;
  typedef logic [SUM_BITS-1:0]    sum_t;
  typedef logic [PROD_BITS-1:0]   prod_t;

  localparam period_t PERIOD_LIMIT  = period_t'(32767);
  localparam period_t AVG_MAX       = '1;
  localparam time_t   TIME_MAX      = '1;
  localparam sum_t    SUM_MAX       = '1;

  localparam time_t   BASE_RESET    = time_t'(6800);
  localparam time_t   ON_RESET      = time_t'(6000);
  localparam time_t   HOLD_RESET    = time_t'(100000);
  localparam period_t AVG_RESET     = period_t'(11000);
  localparam sum_t    SUM_RESET     = sum_t'(176000);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_BASE_DELAY = 2'd0,
    CFG_MAGNET_ON  = 2'd1,
    CFG_HOLDOFF    = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_DELAY = 4'b0010,
    PH_ON    = 4'b0100,
    PH_HOLD  = 4'b1000
  } phase_t;

  typedef enum logic [3:0] {
    SQ_IDLE  = 4'b0001,
    SQ_MUL   = 4'b0010,
    SQ_START = 4'b0100,
    SQ_DIV   = 4'b1000
  } seq_t;

endpackage

FILE: hdl/samp_if.sv
// Valid/ready channel interfaces for the sensor input and the result output.
interface samp_in_if;
  logic valid;
  logic ready;
  logic sensor_level;

  modport source (output valid, output sensor_level, input ready);
  modport sink (input valid, input sensor_level, output ready);
endinterface

interface samp_out_if;
  logic                   valid;
  logic                   ready;
  logic                   magnet_on;
  samp_pkg::period_t      last_period;
  samp_pkg::period_t      average_period;
  logic                   missed;

  modport source (output valid, output magnet_on, output last_period,
                  output average_period, output missed, input ready);
  modport sink (input valid, input magnet_on, input last_period,
                input average_period, input missed, output ready);
endinterface

FILE: hdl/samp_div.sv
// Restoring divider that produces one quotient bit per cycle.
module samp_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  samp_pkg::prod_t     dividend,
  input  samp_pkg::period_t   divisor,
  output logic                done,
  output samp_pkg::prod_t     quotient
);

  localparam logic [samp_pkg::DIV_CNT_BITS-1:0] LAST_STEP =
    samp_pkg::DIV_CNT_BITS'(samp_pkg::PROD_BITS - 1);

  logic [samp_pkg::PERIOD_BITS-1:0]  rem_r;
  logic [samp_pkg::PERIOD_BITS-1:0]  rem_nxt;
  samp_pkg::prod_t                   quo_r;
  logic [samp_pkg::DIV_CNT_BITS-1:0] cnt_r;
  logic                              run_r;
  logic                              done_r;
  logic [samp_pkg::PERIOD_BITS:0]    trial;
  logic                              fits;

  always_comb begin
    trial = {rem_r, quo_r[samp_pkg::PROD_BITS-1]};
    fits  = (trial >= {1'b0, divisor});
    if (fits) begin
      rem_nxt = samp_pkg::PERIOD_BITS'(trial - {1'b0, divisor});
    end else begin
      rem_nxt = trial[samp_pkg::PERIOD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && (cnt_r == LAST_STEP);
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[samp_pkg::PROD_BITS-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: hdl/speed_adaptive_magnet_pulser.sv
// Top level of the speed adaptive magnet pulser.
// The input channel carries one sensor level sample per microsecond tick.
// For every accepted transaction the output channel delivers exactly one
// result transaction: magnet drive, last accepted low period, running
// average and the missed flag. The result is registered and appears in the
// cycle after the input transaction is accepted.
// A tick that does not capture a period leaves the block ready again in the next
// cycle if the receiver takes the result, so such ticks then flow at one per cycle.
// A tick that captures a period keeps in_ch.ready low through SQ_MUL, for the
// unsigned multiply of the period deviation magnitude by the base delay,
// SQ_START, to load the divider, and SQ_DIV, which waits for the bit-serial
// divider and then writes the delay countdown.
// The configuration port writes base delay, on time and holdoff at any
// cycle in which cfg_we is high; writes are expected only while idle.
// A synchronous low rst_n restores the default registers, the average of
// 11000 us and the idle phase. When the receiver stalls, the pending result
// is held and a new input transaction is taken only once it is consumed.
module speed_adaptive_magnet_pulser (
  input  logic                                clk,
  input  logic                                rst_n,
  samp_in_if.sink                             in_ch,
  samp_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [samp_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  samp_pkg::time_t                     cfg_data
);

  samp_pkg::time_t   base_r;
  samp_pkg::time_t   on_r;
  samp_pkg::time_t   hold_r;

  logic              prev_r;
  samp_pkg::period_t low_r;
  logic              ovf_r;
  samp_pkg::period_t period_r;
  samp_pkg::period_t avg_r;
  samp_pkg::sum_t    sum_r;
  samp_pkg::phase_t  phase_r;
  samp_pkg::time_t   countdown_r;
  samp_pkg::seq_t    seq_r;

  samp_pkg::period_t diff_mag_r;
  logic              neg_r;
  samp_pkg::period_t avg_div_r;
  logic              avg_zero_r;
  samp_pkg::prod_t   prod_r;

  logic              out_valid_r;
  logic              out_magnet_r;
  samp_pkg::period_t out_period_r;
  samp_pkg::period_t out_avg_r;
  logic              out_missed_r;

  samp_pkg::phase_t  phase_nxt;
  samp_pkg::time_t   countdown_nxt;
  samp_pkg::period_t low_nxt;
  logic              ovf_nxt;
  samp_pkg::period_t period_nxt;
  samp_pkg::period_t avg_nxt;
  samp_pkg::sum_t    sum_nxt;
  logic              magnet;
  logic              missed;
  logic              capture;
  logic signed [samp_pkg::PERIOD_BITS:0]   diff;
  logic signed [samp_pkg::SUM_BITS+1:0]    sum_ext;
  logic [samp_pkg::PERIOD_BITS:0]          avg_wide;

  logic              in_acc;
  logic              div_start;
  logic              div_done;
  samp_pkg::prod_t   quotient;
  samp_pkg::prod_t   q_use;
  logic [samp_pkg::PROD_BITS:0] pos_sum;
  samp_pkg::time_t   delay;

  assign in_ch.ready = (seq_r == samp_pkg::SQ_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign div_start   = (seq_r == samp_pkg::SQ_START);

  always_comb begin
    phase_nxt     = phase_r;
    countdown_nxt = countdown_r;
    low_nxt       = low_r;
    ovf_nxt       = ovf_r;
    period_nxt    = period_r;
    avg_nxt       = avg_r;
    sum_nxt       = sum_r;
    magnet        = 1'b0;
    missed        = 1'b0;
    capture       = 1'b0;
    diff     = $signed({1'b0, low_r}) - $signed({1'b0, avg_r});
    sum_ext  = $signed({2'b00, sum_r}) +
               $signed({{(samp_pkg::SUM_BITS+1-samp_pkg::PERIOD_BITS){diff[samp_pkg::PERIOD_BITS]}},
                        diff});
    avg_wide = '0;

    if (phase_nxt == samp_pkg::PH_DELAY && countdown_nxt == '0) begin
      phase_nxt     = samp_pkg::PH_ON;
      countdown_nxt = on_r;
    end
    if (phase_nxt == samp_pkg::PH_ON && countdown_nxt == '0) begin
      phase_nxt     = samp_pkg::PH_HOLD;
      countdown_nxt = hold_r;
    end
    if (phase_nxt == samp_pkg::PH_HOLD && countdown_nxt == '0) begin
      phase_nxt = samp_pkg::PH_IDLE;
    end
    if (phase_nxt != samp_pkg::PH_IDLE) begin
      magnet        = (phase_nxt == samp_pkg::PH_ON);
      countdown_nxt = countdown_nxt - 1'b1;
    end

    if (!in_ch.sensor_level) begin
      if (prev_r) begin
        low_nxt = samp_pkg::period_t'(1);
        ovf_nxt = 1'b0;
      end else if (low_r >= samp_pkg::PERIOD_LIMIT) begin
        low_nxt = samp_pkg::PERIOD_LIMIT;
        ovf_nxt = 1'b1;
      end else begin
        low_nxt = low_r + 1'b1;
      end
    end else if (!prev_r && phase_nxt == samp_pkg::PH_IDLE) begin
      if (ovf_r) begin
        missed = 1'b1;
      end else begin
        capture    = 1'b1;
        period_nxt = low_r;
        phase_nxt  = samp_pkg::PH_DELAY;
        if (sum_ext[samp_pkg::SUM_BITS+1]) begin
          sum_nxt = '0;
        end else if (sum_ext[samp_pkg::SUM_BITS]) begin
          sum_nxt = samp_pkg::SUM_MAX;
        end else begin
          sum_nxt = sum_ext[samp_pkg::SUM_BITS-1:0];
        end
        avg_wide = (samp_pkg::PERIOD_BITS+1)'(sum_nxt >> samp_pkg::AVG_SHIFT);
        if (avg_wide[samp_pkg::PERIOD_BITS]) begin
          avg_nxt = samp_pkg::AVG_MAX;
        end else begin
          avg_nxt = avg_wide[samp_pkg::PERIOD_BITS-1:0];
        end
      end
    end
  end

  samp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (avg_div_r),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    q_use   = avg_zero_r ? '0 : quotient;
    pos_sum = {{(samp_pkg::PROD_BITS+1-samp_pkg::TIME_BITS){1'b0}}, base_r} + {1'b0, q_use};
    if (neg_r) begin
      if (q_use > samp_pkg::PROD_BITS'(base_r)) begin
        delay = '0;
      end else begin
        delay = base_r - q_use[samp_pkg::TIME_BITS-1:0];
      end
    end else if (pos_sum > (samp_pkg::PROD_BITS+1)'(samp_pkg::TIME_MAX)) begin
      delay = samp_pkg::TIME_MAX;
    end else begin
      delay = pos_sum[samp_pkg::TIME_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= samp_pkg::BASE_RESET;
      on_r        <= samp_pkg::ON_RESET;
      hold_r      <= samp_pkg::HOLD_RESET;
      prev_r      <= 1'b1;
      low_r       <= '0;
      ovf_r       <= 1'b0;
      period_r    <= '0;
      avg_r       <= samp_pkg::AVG_RESET;
      sum_r       <= samp_pkg::SUM_RESET;
      phase_r     <= samp_pkg::PH_IDLE;
      countdown_r <= '0;
      seq_r       <= samp_pkg::SQ_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          samp_pkg::CFG_BASE_DELAY: base_r <= cfg_data;
          samp_pkg::CFG_MAGNET_ON:  on_r   <= cfg_data;
          samp_pkg::CFG_HOLDOFF:    hold_r <= cfg_data;
          default: ;
        endcase
      end

      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (seq_r)
        samp_pkg::SQ_IDLE: begin
          if (in_acc) begin
            prev_r      <= in_ch.sensor_level;
            low_r       <= low_nxt;
            ovf_r       <= ovf_nxt;
            period_r    <= period_nxt;
            avg_r       <= avg_nxt;
            sum_r       <= sum_nxt;
            phase_r     <= phase_nxt;
            countdown_r <= countdown_nxt;
            if (capture) begin
              seq_r <= samp_pkg::SQ_MUL;
            end
          end
        end
        samp_pkg::SQ_MUL:   seq_r <= samp_pkg::SQ_START;
        samp_pkg::SQ_START: seq_r <= samp_pkg::SQ_DIV;
        samp_pkg::SQ_DIV: begin
          if (div_done) begin
            countdown_r <= delay;
            seq_r       <= samp_pkg::SQ_IDLE;
          end
        end
        default: seq_r <= samp_pkg::SQ_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_magnet_r <= magnet;
      out_period_r <= period_nxt;
      out_avg_r    <= avg_nxt;
      out_missed_r <= missed;
      if (capture) begin
        neg_r      <= diff[samp_pkg::PERIOD_BITS];
        diff_mag_r <= diff[samp_pkg::PERIOD_BITS] ?
                      samp_pkg::PERIOD_BITS'(-diff) : diff[samp_pkg::PERIOD_BITS-1:0];
        avg_div_r  <= avg_r;
        avg_zero_r <= (avg_r == '0);
      end
    end
    if (seq_r == samp_pkg::SQ_MUL) begin
      prod_r <= samp_pkg::PROD_BITS'(diff_mag_r * base_r);
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.magnet_on      = out_magnet_r;
  assign out_ch.last_period    = out_period_r;
  assign out_ch.average_period = out_avg_r;
  assign out_ch.missed         = out_missed_r;

endmodule
